[design/pbgi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbgi_pkg: shared types and constants of the periodic bicubic interpolator
// Command word from the controller, item and register codes, Hermite tables.
// ----------------------------------------------------------------------------
package pbgi_pkg;

    localparam int GRID_X_MAX_DEF = 64;
    localparam int GRID_Y_MAX_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XS_GIVEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YS_GIVEN    = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // neighbor read codes within one corner
    localparam logic [2:0] SUB_CTR = 3'd0;
    localparam logic [2:0] SUB_XP  = 3'd1;
    localparam logic [2:0] SUB_XM  = 3'd2;
    localparam logic [2:0] SUB_YP  = 3'd3;
    localparam logic [2:0] SUB_YM  = 3'd4;

    // term kinds of a corner
    localparam logic [1:0] KIND_VAL = 2'd0;
    localparam logic [1:0] KIND_SX  = 2'd1;
    localparam logic [1:0] KIND_SY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_READ,
        ST_COEF,
        ST_HORN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       store;
        logic       load_query;
        logic       rem_step;
        logic       rd_en;
        logic [1:0] rd_corner;
        logic [2:0] rd_sub;
        logic       coef_en;
        logic [1:0] coef_corner;
        logic [1:0] coef_kind;
        logic       horn_inner;
        logic       horn_outer;
        logic [1:0] horn_i;
        logic [1:0] horn_j;
        logic       out_load;
    } t_cmd;

    localparam logic signed [2:0] HV [2][4] = '{
        '{3'sd1, 3'sd0, -3'sd3, 3'sd2},
        '{3'sd0, 3'sd0, 3'sd3, -3'sd2}
    };
    localparam logic signed [2:0] HS [2][4] = '{
        '{3'sd0, 3'sd1, -3'sd2, 3'sd1},
        '{3'sd0, 3'sd0, -3'sd1, 3'sd1}
    };

    // weight of one corner term in coefficient c[i][j]
    function automatic logic signed [4:0] f_coef(input logic [1:0] corner,
                                                 input logic [1:0] kind,
                                                 input logic [1:0] i,
                                                 input logic [1:0] j);
        logic signed [4:0] a;
        logic signed [4:0] b;
        unique case (kind)
            KIND_SX: begin
                a = 5'(HS[corner[1]][i]);
                b = 5'(HV[corner[0]][j]);
            end
            KIND_SY: begin
                a = 5'(HV[corner[1]][i]);
                b = 5'(HS[corner[0]][j]);
            end
            default: begin
                a = 5'(HV[corner[1]][i]);
                b = 5'(HV[corner[0]][j]);
            end
        endcase
        return 5'(a * b);
    endfunction

    // k*(k-1) for a Horner index
    function automatic logic [2:0] f_kk(input logic [1:0] k);
        unique case (k)
            2'd3:    return 3'd6;
            2'd2:    return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

[design/periodic_bicubic_grid_interpolator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_bicubic_grid_interpolator_core: periodic bicubic grid interpolator
// Loads samples into a periodic grid store and evaluates the bicubic patch,
// its gradients and second derivatives at a fixed-point coordinate.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready   | op, cell, sample, query
//  out      | output    | o_out_valid / i_out_ready | value, grads, curvatures
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  A write item is a single transfer: the store is written at the accept.
//  An evaluate item runs the bit-serial cell wrap, twenty single-port store
//  reads, twelve coefficient steps and twenty Horner steps; the input stays
//  closed until its result is loaded into the output register.
//  Reset (synchronous, active low) restores the register defaults; the store
//  is not cleared. A finished result waits in the output register while the
//  next items are accepted; a second result stalls until the first is taken.
// ----------------------------------------------------------------------------
module periodic_bicubic_grid_interpolator_core import pbgi_pkg::*; #(
    parameter int GRID_X_MAX = GRID_X_MAX_DEF,
    parameter int GRID_Y_MAX = GRID_Y_MAX_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_op,
    input  wire logic [5:0]            i_cell_x,
    input  wire logic [5:0]            i_cell_y,
    input  wire logic signed [31:0]    i_sample_value,
    input  wire logic signed [31:0]    i_slope_x_in,
    input  wire logic signed [31:0]    i_slope_y_in,
    input  wire logic signed [31:0]    i_query_x,
    input  wire logic signed [31:0]    i_query_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [47:0]         o_value_out,
    output logic signed [47:0]         o_grad_x,
    output logic signed [47:0]         o_grad_y,
    output logic signed [47:0]         o_curv_xx,
    output logic signed [47:0]         o_curv_yy,
    output logic signed [47:0]         o_curv_xy
);
    // configuration registers; indexes beyond the list are dropped
    logic [6:0] r_grid_width;
    logic [6:0] r_grid_height;
    logic       r_central;
    logic       r_xs_given;
    logic       r_ys_given;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
            r_central     <= 1'b1;
            r_xs_given    <= 1'b0;
            r_ys_given    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_CENTRAL:     r_central     <= i_cfg_data[0];
                CFG_XS_GIVEN:    r_xs_given    <= i_cfg_data[0];
                CFG_YS_GIVEN:    r_ys_given    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // controller drives one command word a cycle into the datapath
    t_cmd w_cmd;

    pbgi_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    pbgi_datapath #(
        .GRID_X_MAX (GRID_X_MAX),
        .GRID_Y_MAX (GRID_Y_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .i_central      (r_central),
        .i_xs_given     (r_xs_given),
        .i_ys_given     (r_ys_given),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_sample_value (i_sample_value),
        .i_slope_x_in   (i_slope_x_in),
        .i_slope_y_in   (i_slope_y_in),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .o_value_out    (o_value_out),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_curv_xx      (o_curv_xx),
        .o_curv_yy      (o_curv_yy),
        .o_curv_xy      (o_curv_xy)
    );

    // an evaluate transfer closes the input until its result is loaded
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op == OP_EVAL) |=> !o_in_ready)
        else $error("input ready after evaluate transfer");

    // a result is only loaded into a free or draining output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    // a write transfer never produces a result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op == OP_WRITE && !o_out_valid)
        |=> !o_out_valid)
        else $error("result after write transfer");

endmodule
`default_nettype wire

[design/pbgi_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbgi_ctrl: sequencer of the bicubic interpolator
// Walks wrap, gather, coefficient and Horner phases; owns the output valid.
// ----------------------------------------------------------------------------
module pbgi_ctrl import pbgi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_op,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);
    localparam int IB   = 32 - FRAC_BITS;
    localparam int CNTW = $clog2(IB);

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [1:0]        r_a, n_a;
    logic [2:0]        r_b, n_b;
    logic              r_outer, n_outer;
    logic              r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_outer  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_a      <= n_a;
            r_b      <= n_b;
            r_outer  <= n_outer;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_a        = r_a;
        n_b        = r_b;
        n_outer    = r_outer;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_EVAL) begin
                        o_cmd.load_query = 1'b1;
                        n_cnt            = '0;
                        n_state          = ST_WRAP;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            ST_WRAP: begin
                o_cmd.rem_step = 1'b1;
                n_cnt          = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(IB - 1)) begin
                    n_a     = '0;
                    n_b     = SUB_CTR;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_corner = r_a;
                o_cmd.rd_sub    = r_b;
                if (r_b == SUB_YM) begin
                    n_b = SUB_CTR;
                    n_a = r_a + 2'd1;
                    if (r_a == 2'd3) begin
                        n_b     = {1'b0, KIND_VAL};
                        n_state = ST_COEF;
                    end
                end else begin
                    n_b = r_b + 3'd1;
                end
            end
            ST_COEF: begin
                o_cmd.coef_en     = 1'b1;
                o_cmd.coef_corner = r_a;
                o_cmd.coef_kind   = r_b[1:0];
                if (r_b[1:0] == KIND_SY) begin
                    n_b = {1'b0, KIND_VAL};
                    n_a = r_a + 2'd1;
                    if (r_a == 2'd3) begin
                        n_a     = 2'd3;
                        n_b     = 3'd3;
                        n_outer = 1'b0;
                        n_state = ST_HORN;
                    end
                end else begin
                    n_b = r_b + 3'd1;
                end
            end
            ST_HORN: begin
                o_cmd.horn_i = r_a;
                o_cmd.horn_j = r_b[1:0];
                if (!r_outer) begin
                    o_cmd.horn_inner = 1'b1;
                    if (r_b[1:0] == 2'd0) begin
                        n_outer = 1'b1;
                    end else begin
                        n_b = r_b - 3'd1;
                    end
                end else begin
                    o_cmd.horn_outer = 1'b1;
                    n_outer          = 1'b0;
                    n_b              = 3'd3;
                    if (r_a == 2'd0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_a = r_a - 2'd1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

[design/pbgi_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbgi_datapath: grid stores, cell wrap, coefficient and Horner datapath
// Executes one command word a cycle; holds the result registers.
// ----------------------------------------------------------------------------
module pbgi_datapath import pbgi_pkg::*; #(
    parameter int GRID_X_MAX = GRID_X_MAX_DEF,
    parameter int GRID_Y_MAX = GRID_Y_MAX_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [6:0]         i_grid_width,
    input  wire logic [6:0]         i_grid_height,
    input  wire logic               i_central,
    input  wire logic               i_xs_given,
    input  wire logic               i_ys_given,
    input  wire logic [5:0]         i_cell_x,
    input  wire logic [5:0]         i_cell_y,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic signed [31:0] i_slope_x_in,
    input  wire logic signed [31:0] i_slope_y_in,
    input  wire logic signed [31:0] i_query_x,
    input  wire logic signed [31:0] i_query_y,
    output logic signed [47:0]      o_value_out,
    output logic signed [47:0]      o_grad_x,
    output logic signed [47:0]      o_grad_y,
    output logic signed [47:0]      o_curv_xx,
    output logic signed [47:0]      o_curv_yy,
    output logic signed [47:0]      o_curv_xy
);
    localparam int XW    = $clog2(GRID_X_MAX);
    localparam int YW    = $clog2(GRID_Y_MAX);
    localparam int NXW   = $clog2(GRID_X_MAX + 1);
    localparam int NYW   = $clog2(GRID_Y_MAX + 1);
    localparam int DEPTH = GRID_X_MAX * GRID_Y_MAX;
    localparam int AMW   = $clog2(DEPTH);
    localparam int F     = FRAC_BITS;
    localparam int IB    = 32 - F;
    localparam int GW    = 33;
    localparam int CW    = 41;
    localparam int AW    = 54;
    localparam int PW    = AW + F + 1;
    localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-47){1'b0}}, {47{1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-47){1'b1}}, {47{1'b0}}};

    function automatic logic [XW-1:0] f_incx(input logic [XW-1:0] p,
                                             input logic [NXW-1:0] n);
        return (NXW'(p) == n - NXW'(1)) ? '0 : p + XW'(1);
    endfunction
    function automatic logic [XW-1:0] f_decx(input logic [XW-1:0] p,
                                             input logic [NXW-1:0] n);
        return (p == '0) ? XW'(n - NXW'(1)) : p - XW'(1);
    endfunction
    function automatic logic [YW-1:0] f_incy(input logic [YW-1:0] p,
                                             input logic [NYW-1:0] n);
        return (NYW'(p) == n - NYW'(1)) ? '0 : p + YW'(1);
    endfunction
    function automatic logic [YW-1:0] f_decy(input logic [YW-1:0] p,
                                             input logic [NYW-1:0] n);
        return (p == '0) ? YW'(n - NYW'(1)) : p - YW'(1);
    endfunction
    function automatic logic signed [AW-1:0] f_scale(input logic signed [AW-1:0] v,
                                                     input logic [2:0] k);
        return v * AW'($signed({1'b0, k}));
    endfunction
    function automatic logic [47:0] f_finish(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] h;
        h = (v + AW'(1)) >>> 1;
        if (h > SAT_HI) begin
            h = SAT_HI;
        end else if (h < SAT_LO) begin
            h = SAT_LO;
        end
        return h[47:0];
    endfunction

    // effective grid size
    logic [NXW-1:0] nw;
    logic [NYW-1:0] nh;
    always_comb begin
        if (i_grid_width == '0) begin
            nw = NXW'(1);
        end else if (32'(i_grid_width) > GRID_X_MAX) begin
            nw = NXW'(GRID_X_MAX);
        end else begin
            nw = NXW'(i_grid_width);
        end
        if (i_grid_height == '0) begin
            nh = NYW'(1);
        end else if (32'(i_grid_height) > GRID_Y_MAX) begin
            nh = NYW'(GRID_Y_MAX);
        end else begin
            nh = NYW'(i_grid_height);
        end
    end

    // bit-serial remainder of the integer coordinate
    logic [IB-1:0]  r_ux, r_uy;
    logic [NXW-1:0] r_rx;
    logic [NYW-1:0] r_ry;
    logic           r_negx, r_negy;
    logic [F-1:0]   r_fx, r_fy;
    logic [NXW:0]   tx;
    logic [NYW:0]   ty;

    assign tx = {r_rx, r_ux[IB-1]};
    assign ty = {r_ry, r_uy[IB-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_negx <= i_query_x[31];
            r_negy <= i_query_y[31];
            r_ux   <= i_query_x[31] ? ~i_query_x[31:F] : i_query_x[31:F];
            r_uy   <= i_query_y[31] ? ~i_query_y[31:F] : i_query_y[31:F];
            r_rx   <= '0;
            r_ry   <= '0;
            r_fx   <= i_query_x[F-1:0];
            r_fy   <= i_query_y[F-1:0];
        end else if (i_cmd.rem_step) begin
            r_ux <= r_ux << 1;
            r_uy <= r_uy << 1;
            r_rx <= (tx >= {1'b0, nw}) ? NXW'(tx - {1'b0, nw}) : NXW'(tx);
            r_ry <= (ty >= {1'b0, nh}) ? NYW'(ty - {1'b0, nh}) : NYW'(ty);
        end
    end

    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    assign bx = XW'(r_negx ? NXW'(nw - NXW'(1) - r_rx) : r_rx);
    assign by = YW'(r_negy ? NYW'(nh - NYW'(1) - r_ry) : r_ry);

    // stores
    logic [31:0] mem_v  [DEPTH];
    logic [31:0] mem_sx [DEPTH];
    logic [31:0] mem_sy [DEPTH];
    logic [31:0] r_rdv, r_rdx, r_rdy;

    logic [AMW-1:0] waddr, raddr;
    logic           w_inr;
    logic [XW-1:0]  pxc, rx;
    logic [YW-1:0]  pyc, ry;

    assign w_inr = (32'(i_cell_x) < GRID_X_MAX) && (32'(i_cell_y) < GRID_Y_MAX);
    assign waddr = AMW'(AMW'(XW'(i_cell_x)) * AMW'(GRID_Y_MAX) + AMW'(YW'(i_cell_y)));

    always_comb begin
        pxc = i_cmd.rd_corner[1] ? f_incx(bx, nw) : bx;
        pyc = i_cmd.rd_corner[0] ? f_incy(by, nh) : by;
        rx  = pxc;
        ry  = pyc;
        unique case (i_cmd.rd_sub)
            SUB_XP:  rx = f_incx(pxc, nw);
            SUB_XM:  rx = f_decx(pxc, nw);
            SUB_YP:  ry = f_incy(pyc, nh);
            SUB_YM:  ry = f_decy(pyc, nh);
            default: rx = pxc;
        endcase
        raddr = AMW'(AMW'(rx) * AMW'(GRID_Y_MAX) + AMW'(ry));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_inr) begin
            mem_v[waddr]  <= i_sample_value;
            mem_sx[waddr] <= i_slope_x_in;
            mem_sy[waddr] <= i_slope_y_in;
        end
        if (i_cmd.rd_en) begin
            r_rdv <= mem_v[raddr];
            r_rdx <= mem_sx[raddr];
            r_rdy <= mem_sy[raddr];
        end
    end

    // gather: doubled value and slopes per corner
    logic       r_cap_en;
    logic [1:0] r_cap_corner;
    logic [2:0] r_cap_sub;
    logic signed [GW-1:0] r_gv [4];
    logic signed [GW-1:0] r_gsx [4];
    logic signed [GW-1:0] r_gsy [4];
    logic signed [GW-1:0] rdv_ext;

    assign rdv_ext = {r_rdv[31], r_rdv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_corner <= i_cmd.rd_corner;
        r_cap_sub    <= i_cmd.rd_sub;
        if (r_cap_en) begin
            unique case (r_cap_sub)
                SUB_CTR: begin
                    r_gv[r_cap_corner] <= {r_rdv, 1'b0};
                    if (!i_central) begin
                        r_gsx[r_cap_corner] <= i_xs_given ? {r_rdx, 1'b0} : '0;
                        r_gsy[r_cap_corner] <= i_ys_given ? {r_rdy, 1'b0} : '0;
                    end
                end
                SUB_XP: if (i_central) r_gsx[r_cap_corner] <= rdv_ext;
                SUB_XM: if (i_central) r_gsx[r_cap_corner] <= r_gsx[r_cap_corner] - rdv_ext;
                SUB_YP: if (i_central) r_gsy[r_cap_corner] <= rdv_ext;
                SUB_YM: if (i_central) r_gsy[r_cap_corner] <= r_gsy[r_cap_corner] - rdv_ext;
                default: ;
            endcase
        end
    end

    // coefficients: one corner term added into all sixteen per cycle
    logic signed [CW-1:0] r_c [4][4];
    logic signed [GW-1:0] term;

    always_comb begin
        unique case (i_cmd.coef_kind)
            KIND_SX: term = r_gsx[i_cmd.coef_corner];
            KIND_SY: term = r_gsy[i_cmd.coef_corner];
            default: term = r_gv[i_cmd.coef_corner];
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (i_cmd.load_query) begin
                    r_c[i][j] <= '0;
                end else if (i_cmd.coef_en) begin
                    r_c[i][j] <= r_c[i][j] + CW'(term * f_coef(i_cmd.coef_corner,
                                 i_cmd.coef_kind, 2'(i), 2'(j)));
                end
            end
        end
    end

    // Horner lanes
    logic signed [AW-1:0] r_s, r_sd, r_s2;
    logic signed [AW-1:0] r_f, r_gx, r_cxx, r_gy, r_cyy, r_cxy;
    logic signed [AW-1:0] opnd [6];
    logic signed [AW-1:0] mres [6];
    logic signed [PW-1:0] prod [6];
    logic signed [AW-1:0] cext;
    logic [F-1:0]         dmul;
    logic                 first_in, first_out;

    assign cext      = AW'(r_c[i_cmd.horn_i][i_cmd.horn_j]);
    assign dmul      = i_cmd.horn_outer ? r_fx : r_fy;
    assign first_in  = (i_cmd.horn_j == 2'd3);
    assign first_out = (i_cmd.horn_i == 2'd3);

    always_comb begin
        if (i_cmd.horn_outer) begin
            opnd[0] = first_out ? '0 : r_f;
            opnd[1] = first_out ? '0 : r_gx;
            opnd[2] = first_out ? '0 : r_cxx;
            opnd[3] = first_out ? '0 : r_gy;
            opnd[4] = first_out ? '0 : r_cyy;
            opnd[5] = first_out ? '0 : r_cxy;
        end else begin
            opnd[0] = first_in ? '0 : r_s;
            opnd[1] = first_in ? '0 : r_sd;
            opnd[2] = first_in ? '0 : r_s2;
            opnd[3] = '0;
            opnd[4] = '0;
            opnd[5] = '0;
        end
        for (int k = 0; k < 6; k++) begin
            prod[k] = PW'(opnd[k]) * PW'($signed({1'b0, dmul}));
            mres[k] = AW'((prod[k] + HALF) >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.horn_inner) begin
            r_s <= mres[0] + cext;
            if (i_cmd.horn_j != 2'd0) begin
                r_sd <= mres[1] + f_scale(cext, {1'b0, i_cmd.horn_j});
            end
            if (i_cmd.horn_j > 2'd1) begin
                r_s2 <= mres[2] + f_scale(cext, f_kk(i_cmd.horn_j));
            end
        end
        if (i_cmd.horn_outer) begin
            r_f  <= mres[0] + r_s;
            r_gy <= mres[3] + r_sd;
            r_cyy <= mres[4] + r_s2;
            if (i_cmd.horn_i != 2'd0) begin
                r_gx  <= mres[1] + f_scale(r_s, {1'b0, i_cmd.horn_i});
                r_cxy <= mres[5] + f_scale(r_sd, {1'b0, i_cmd.horn_i});
            end
            if (i_cmd.horn_i > 2'd1) begin
                r_cxx <= mres[2] + f_scale(r_s, f_kk(i_cmd.horn_i));
            end
        end
        if (i_cmd.out_load) begin
            o_value_out <= f_finish(r_f);
            o_grad_x    <= f_finish(r_gx);
            o_grad_y    <= f_finish(r_gy);
            o_curv_xx   <= f_finish(r_cxx);
            o_curv_yy   <= f_finish(r_cyy);
            o_curv_xy   <= f_finish(r_cxy);
        end
    end

endmodule
`default_nettype wire

[tb/sv/periodic_bicubic_grid_interpolator_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_bicubic_grid_interpolator_core_tb: self-checking bench of the core
// Fills the periodic grid, evaluates patches under several grid sizes and
// slope modes with random idling on both channels, and compares every
// result field against a bit-true bicubic predictor kept in the bench.
// ----------------------------------------------------------------------------
module periodic_bicubic_grid_interpolator_core_tb;
    import pbgi_pkg::*;

    localparam int  GX = 64;
    localparam int  GY = 64;
    localparam int  FB = 16;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;

    typedef struct {
        logic [47:0] val;
        logic [47:0] gx;
        logic [47:0] gy;
        logic [47:0] cxx;
        logic [47:0] cyy;
        logic [47:0] cxy;
    } t_patch;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_op = OP_WRITE;
    logic [5:0]            i_cell_x = '0;
    logic [5:0]            i_cell_y = '0;
    logic signed [31:0]    i_sample_value = '0;
    logic signed [31:0]    i_slope_x_in = '0;
    logic signed [31:0]    i_slope_y_in = '0;
    logic signed [31:0]    i_query_x = '0;
    logic signed [31:0]    i_query_y = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [47:0]    o_value_out, o_grad_x, o_grad_y;
    logic signed [47:0]    o_curv_xx, o_curv_yy, o_curv_xy;

    periodic_bicubic_grid_interpolator_core u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_op, .i_cell_x, .i_cell_y,
        .i_sample_value, .i_slope_x_in, .i_slope_y_in, .i_query_x, .i_query_y,
        .o_out_valid, .i_out_ready, .o_value_out, .o_grad_x, .o_grad_y,
        .o_curv_xx, .o_curv_yy, .o_curv_xy
    );

    always #1 i_clk = ~i_clk;

    // bench copy of grid store and registers
    longint grid_val [GX*GY];
    longint grid_sx  [GX*GY];
    longint grid_sy  [GX*GY];
    bit     grid_written [GX*GY];
    int     cfg_w, cfg_h;
    bit     cfg_cd, cfg_xs, cfg_ys;

    t_patch patch_q[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     n_err = 0;
    int     n_items = 0;
    int     n_evals = 0;
    int     n_checked = 0;
    longint cyc = 0;

    const longint HVAL [2][4] = '{'{1, 0, -3, 2}, '{0, 0, 3, -2}};
    const longint HSLP [2][4] = '{'{0, 1, -2, 1}, '{0, 0, -1, 1}};

    // ------------------------------------------------------------------
    // predictor arithmetic
    // ------------------------------------------------------------------
    function automatic longint mod_wrap(longint v, longint n);
        longint r;
        r = v % n;
        return (r < 0) ? r + n : r;
    endfunction

    // acc * frac with round-half-up back to coefficient scale
    function automatic longint frac_mul(longint a, longint d);
        longint r, q, lo;
        r  = a & ((64'sd1 << FB) - 1);
        q  = (a - r) >>> FB;
        lo = (r * d + (64'sd1 << (FB - 1))) >>> FB;
        return q * d + lo;
    endfunction

    // halve (ties up) and saturate to 48 bits
    function automatic logic [47:0] halve_sat(longint v);
        longint h;
        h = (v + 1) >>> 1;
        if (h > SAT_HI) h = SAT_HI;
        if (h < SAT_LO) h = SAT_LO;
        return h[47:0];
    endfunction

    function automatic int clamp_size(int r, int mx);
        return (r < 1) ? 1 : ((r > mx) ? mx : r);
    endfunction

    // true when every entry a query can touch has been written
    function automatic bit fp_ok(logic signed [31:0] qx, logic signed [31:0] qy);
        longint nw, nh, bx, by;
        nw = clamp_size(cfg_w, GX);
        nh = clamp_size(cfg_h, GY);
        bx = mod_wrap(longint'(qx) >>> FB, nw);
        by = mod_wrap(longint'(qy) >>> FB, nh);
        for (int dx = -1; dx <= 2; dx++)
            for (int dy = -1; dy <= 2; dy++)
                if (!grid_written[mod_wrap(bx + dx, nw) * GY + mod_wrap(by + dy, nh)])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_patch eval_patch(logic signed [31:0] qx, logic signed [31:0] qy);
        longint nw, nh, fx, fy, bx, by, px, py, a, v2, sx2, sy2;
        longint c[4][4];
        longint f, gx, gy, cxx, cyy, cxy, s, sd, s2;
        t_patch p;
        nw = clamp_size(cfg_w, GX);
        nh = clamp_size(cfg_h, GY);
        fx = longint'(qx) & ((64'sd1 << FB) - 1);
        fy = longint'(qy) & ((64'sd1 << FB) - 1);
        bx = mod_wrap(longint'(qx) >>> FB, nw);
        by = mod_wrap(longint'(qy) >>> FB, nh);
        foreach (c[i, j]) c[i][j] = 0;
        for (int cx = 0; cx < 2; cx++) begin
            for (int cy = 0; cy < 2; cy++) begin
                px = mod_wrap(bx + cx, nw);
                py = mod_wrap(by + cy, nh);
                a  = px * GY + py;
                v2 = 2 * grid_val[a];
                if (cfg_cd) begin
                    sx2 = grid_val[mod_wrap(px + 1, nw) * GY + py]
                        - grid_val[mod_wrap(px - 1, nw) * GY + py];
                    sy2 = grid_val[px * GY + mod_wrap(py + 1, nh)]
                        - grid_val[px * GY + mod_wrap(py - 1, nh)];
                end else begin
                    sx2 = cfg_xs ? 2 * grid_sx[a] : 0;
                    sy2 = cfg_ys ? 2 * grid_sy[a] : 0;
                end
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        c[i][j] += v2 * HVAL[cx][i] * HVAL[cy][j]
                                 + sx2 * HSLP[cx][i] * HVAL[cy][j]
                                 + sy2 * HVAL[cx][i] * HSLP[cy][j];
            end
        end
        f = 0; gx = 0; gy = 0; cxx = 0; cyy = 0; cxy = 0;
        for (int i = 3; i >= 0; i--) begin
            s = 0; sd = 0; s2 = 0;
            for (int j = 3; j >= 0; j--) begin
                s = frac_mul(s, fy) + c[i][j];
                if (j > 0) sd = frac_mul(sd, fy) + j * c[i][j];
                if (j > 1) s2 = frac_mul(s2, fy) + j * (j - 1) * c[i][j];
            end
            f = frac_mul(f, fx) + s;
            if (i > 0) gx = frac_mul(gx, fx) + i * s;
            if (i > 1) cxx = frac_mul(cxx, fx) + i * (i - 1) * s;
            gy  = frac_mul(gy, fx) + sd;
            cyy = frac_mul(cyy, fx) + s2;
            if (i > 0) cxy = frac_mul(cxy, fx) + i * sd;
        end
        p.val = halve_sat(f);   p.gx  = halve_sat(gx);  p.gy  = halve_sat(gy);
        p.cxx = halve_sat(cxx); p.cyy = halve_sat(cyy); p.cxy = halve_sat(cxy);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_item(logic op, logic [5:0] cx, logic [5:0] cy,
                             logic [31:0] sv, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] qx, logic [31:0] qy);
        int a;
        // random gap before the next transfer; valid drops only for a gap
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_cell_x       <= cx;
        i_cell_y       <= cy;
        i_sample_value <= sv;
        i_slope_x_in   <= sx;
        i_slope_y_in   <= sy;
        i_query_x      <= qx;
        i_query_y      <= qy;
        // hold until the transfer
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (op == OP_WRITE) begin
            a = int'(cx) * GY + int'(cy);
            grid_val[a] = longint'($signed(sv));
            grid_sx[a]  = longint'($signed(sx));
            grid_sy[a]  = longint'($signed(sy));
            grid_written[a] = 1'b1;
        end else begin
            patch_q.push_back(eval_patch(qx, qy));
            n_evals++;
        end
    endtask

    task automatic write_cell(int x, int y, logic [31:0] v);
        send_item(OP_WRITE, 6'(x), 6'(y), v, $urandom, $urandom, $urandom, $urandom);
    endtask

    // random coordinate: mostly near the grid, sometimes anywhere
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 400)) - 200) << FB | 32'($urandom_range(65535));
    endfunction

    task automatic eval_at(logic [31:0] qx, logic [31:0] qy);
        send_item(OP_EVAL, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom, qx, qy);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (patch_q.size() != 0) @(posedge i_clk);
        // let any trailing evaluate work settle
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_GRID_WIDTH:  cfg_w  = val;
            CFG_GRID_HEIGHT: cfg_h  = val;
            CFG_CENTRAL:     cfg_cd = val[0];
            CFG_XS_GIVEN:    cfg_xs = val[0];
            default:         cfg_ys = val[0];
        endcase
    endtask

    task automatic configure(int w, int h, bit cd, bit xs, bit ys);
        drain();
        set_reg(CFG_GRID_WIDTH, w);
        set_reg(CFG_GRID_HEIGHT, h);
        set_reg(CFG_CENTRAL, cd);
        set_reg(CFG_XS_GIVEN, xs);
        set_reg(CFG_YS_GIVEN, ys);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // fill the low and high border block of the store; queries only touch
    // written entries
    task automatic test_fill_grid();
        for (int x = 0; x < GX; x++)
            for (int y = 0; y < GY; y++) begin
                if ((x < 8 || x >= GX - 4) && (y < 8 || y >= GY - 4)) begin
                    if ($urandom_range(3) == 0) write_cell(x, y, $urandom);
                    else write_cell(x, y, 32'($signed($urandom_range(0, 2000000)) - 1000000));
                end
            end
    endtask

    task automatic test_directed();
        configure(64, 64, 1, 0, 0);
        // extreme samples feed saturation
        write_cell(0, 0, 32'h7fffffff);
        write_cell(1, 0, 32'h80000000);
        write_cell(0, 1, 32'h80000000);
        write_cell(63, 63, 32'h7fffffff);
        // drop: store index beyond the grid does not exist here, max cell index
        send_item(OP_WRITE, 6'h3f, 6'h00, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                  32'h0, 32'h0);
        eval_at(32'h0, 32'h0);
        eval_at(32'h0000ffff, 32'h0000ffff);
        eval_at(32'h7fffffff, 32'h7fffffff);
        eval_at(32'h80000000, 32'h80000000);
        eval_at(32'hffff8000, 32'h003f8000);
        // zero size acts as one; oversize acts as the maximum; narrow grids
        configure(0, 0, 1, 1, 1);
        eval_at(32'h00058000, 32'hfffd0001);
        configure(127, 127, 1, 0, 0);
        eval_at(32'h00408000, 32'hffc04000);
        configure(2, 1, 1, 0, 0);
        eval_at(32'h00014000, 32'h00020000);
        configure(1, 2, 0, 1, 1);
        eval_at(32'h7fff0001, 32'h80001234);
        configure(64, 64, 0, 0, 0);
        eval_at(32'h00028000, 32'h00018000);
        configure(64, 64, 0, 1, 0);
        eval_at(32'h00028000, 32'h00018000);
        configure(64, 64, 0, 0, 1);
        eval_at(32'h00028000, 32'h00018000);
    endtask

    task automatic test_random(int count);
        logic [31:0] qx, qy;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0)
                write_cell($urandom_range(63), $urandom_range(63),
                           ($urandom_range(7) == 0) ? $urandom
                           : 32'($signed($urandom_range(0, 4000000)) - 2000000));
            else begin
                do begin
                    qx = rand_coord();
                    qy = rand_coord();
                end while (!fp_ok(qx, qy));
                eval_at(qx, qy);
            end
        end
    endtask

    task automatic test_settings_sweep();
        int sizes[6] = '{1, 2, 3, 17, 63, 64};
        for (int p = 0; p < 6; p++) begin
            configure(sizes[p], sizes[5 - p], p[0], p[1], $urandom_range(1));
            test_random(25);
        end
        configure(64, 64, 1, 0, 0);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(70);
        send_idle_pct = 85; recv_stall_pct = 0;  test_random(50);
        // hold off the sender until every pending result is out
        drain();
        send_idle_pct = 0;  recv_stall_pct = 85; test_random(50);
        send_idle_pct = 23; recv_stall_pct = 23; test_random(70);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        n_err++;
        $display("mismatch %s at cycle %0d: got %h want %h", what, cyc, got, want);
    endtask

    always @(posedge i_clk) begin
        t_patch w;
        cyc <= cyc + 1;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (patch_q.size() == 0) begin
                report_mismatch("unexpected result", o_value_out, 48'h0);
            end else begin
                w = patch_q.pop_front();
                n_checked++;
                if (o_value_out !== w.val) report_mismatch("value", o_value_out, w.val);
                if (o_grad_x    !== w.gx)  report_mismatch("grad_x", o_grad_x, w.gx);
                if (o_grad_y    !== w.gy)  report_mismatch("grad_y", o_grad_y, w.gy);
                if (o_curv_xx   !== w.cxx) report_mismatch("curv_xx", o_curv_xx, w.cxx);
                if (o_curv_yy   !== w.cyy) report_mismatch("curv_yy", o_curv_yy, w.cyy);
                if (o_curv_xy   !== w.cxy) report_mismatch("curv_xy", o_curv_xy, w.cxy);
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("[periodic_bicubic_grid_interpolator_core] ERROR");
            $finish;
        end
    end

    initial begin
        cfg_w = 64; cfg_h = 64; cfg_cd = 1; cfg_xs = 0; cfg_ys = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_grid();
        test_directed();
        test_settings_sweep();
        test_idle_phases();
        drain();
        if (patch_q.size() != 0) n_err++;
        $display("covered %0d items, %0d evaluations, %0d results checked", n_items,
                 n_evals, n_checked);
        $display("grid sizes 0..127, all slope modes, idle and stall phases");
        if (n_err == 0)
            $display("[periodic_bicubic_grid_interpolator_core] OK");
        else
            $display("[periodic_bicubic_grid_interpolator_core] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

[periodic_bicubic_grid_interpolator_core.f]
design/pbgi_pkg.sv
design/pbgi_ctrl.sv
design/pbgi_datapath.sv
design/periodic_bicubic_grid_interpolator_core.sv
tb/sv/periodic_bicubic_grid_interpolator_core_tb.sv
